/* sv/ttps_pkg.sv */
// shared constants, codes and types of the transposition table probe store
package ttps_pkg;

  // table geometry: slot count is the entry count rounded down to a power of two
  localparam int unsigned ENTRY_COUNT = 4096;
  localparam int unsigned SLOT_BITS   = $clog2(ENTRY_COUNT + 1) - 1;
  localparam int unsigned SLOT_COUNT  = 1 << SLOT_BITS;

  // field widths
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned SCORE_BITS = 16;
  localparam int unsigned DEPTH_BITS = 8;
  localparam int unsigned MOVE_BITS  = 16;
  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned BOUND_BITS = 2;

  // operation codes of an item
  typedef enum logic [MODE_BITS-1:0] {
    MODE_RECORD = 2'd0,
    MODE_PROBE  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // bound kinds held with an entry
  typedef enum logic [BOUND_BITS-1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2
  } bound_e;

  // one table slot as stored in memory
  typedef struct packed {
    logic                         valid;
    logic signed [SCORE_BITS-1:0] score;
    logic [BOUND_BITS-1:0]        bound;
    logic [DEPTH_BITS-1:0]        depth;
    logic [MOVE_BITS-1:0]         move;
    logic [KEY_BITS-1:0]          key;
  } slot_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;      // item taken, latch probe fields
    logic wr_record;   // write the incoming entry into its slot
    logic rd_probe;    // read the slot addressed by the incoming key
    logic sweep_step;  // zero the slot under the sweep counter
    logic load_out;    // load the result register
    logic out_probe;   // result comes from the probe, else all zero
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_last;  // sweep counter on the last slot
    logic out_free;    // result register can take a new item
  } sts_t;

endpackage

/* sv/ttps_if.sv */
// request and response channel interfaces of the transposition table probe store
interface ttps_req_if import ttps_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [MODE_BITS-1:0]         mode;
  logic [KEY_BITS-1:0]          position_key;
  logic [DEPTH_BITS-1:0]        search_depth;
  logic signed [SCORE_BITS-1:0] window_low;
  logic signed [SCORE_BITS-1:0] window_high;
  logic signed [SCORE_BITS-1:0] store_score;
  logic [BOUND_BITS-1:0]        bound_kind;
  logic [MOVE_BITS-1:0]         best_move;
  logic                         cancelled;

  modport source (
    output valid, mode, position_key, search_depth, window_low, window_high,
           store_score, bound_kind, best_move, cancelled,
    input  ready
  );
  modport sink (
    input  valid, mode, position_key, search_depth, window_low, window_high,
           store_score, bound_kind, best_move, cancelled,
    output ready
  );
endinterface

interface ttps_rsp_if import ttps_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         score_known;
  logic signed [SCORE_BITS-1:0] score;
  logic [MOVE_BITS-1:0]         stored_move;

  modport source (
    output valid, score_known, score, stored_move,
    input  ready
  );
  modport sink (
    input  valid, score_known, score, stored_move,
    output ready
  );
endinterface

/* sv/ttps_ctrl.sv */
// controller state machine: sequences record, probe, clear sweep and result load
module ttps_ctrl import ttps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic [MODE_BITS-1:0] req_mode_i,
  input  logic                 req_cancelled_i,
  output logic                 req_ready_o,
  input  sts_t                 sts_i,
  output cmd_t                 cmd_o
);

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_BUSY  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;    // clear item owes a result after the sweep
  logic   probe_q, probe_d;  // pending result comes from a probe

  assign req_ready_o = (state_q == ST_IDLE);

  // next state and command decode
  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    probe_d = probe_q;
    cmd_o   = '0;
    cmd_o.out_probe = probe_q;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = emit_q ? ST_BUSY : ST_IDLE;
          emit_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          probe_d      = 1'b0;
          state_d      = ST_BUSY;
          case (req_mode_i)
            MODE_RECORD: begin
              cmd_o.wr_record = !req_cancelled_i;
            end
            MODE_PROBE: begin
              cmd_o.rd_probe = 1'b1;
              probe_d        = 1'b1;
            end
            MODE_CLEAR: begin
              state_d = ST_SWEEP;
              emit_d  = 1'b1;
            end
            default: begin
              // unused code: no operation, zero result
            end
          endcase
        end
      end
      ST_BUSY: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

  // state registers, reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      emit_q  <= 1'b0;
      probe_q <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
      probe_q <= probe_d;
    end
  end

endmodule

/* sv/ttps_dp.sv */
// datapath: slot memory, sweep counter, probe compare and result register
module ttps_dp import ttps_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  input  logic [KEY_BITS-1:0]          req_key_i,
  input  logic [DEPTH_BITS-1:0]        req_depth_i,
  input  logic signed [SCORE_BITS-1:0] req_alpha_i,
  input  logic signed [SCORE_BITS-1:0] req_beta_i,
  input  logic signed [SCORE_BITS-1:0] req_score_i,
  input  logic [BOUND_BITS-1:0]        req_bound_i,
  input  logic [MOVE_BITS-1:0]         req_move_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic                         rsp_known_o,
  output logic signed [SCORE_BITS-1:0] rsp_score_o,
  output logic [MOVE_BITS-1:0]         rsp_move_o
);

  slot_t                        slot_mem_q [SLOT_COUNT];
  slot_t                        rdata_q;
  slot_t                        rec_slot;
  slot_t                        wr_data;
  logic [SLOT_BITS-1:0]         wr_addr;
  logic                         wr_en;
  logic [SLOT_BITS-1:0]         req_idx;
  logic [SLOT_BITS-1:0]         sweep_cnt_q;
  logic [KEY_BITS-1:0]          key_q;
  logic [DEPTH_BITS-1:0]        depth_q;
  logic signed [SCORE_BITS-1:0] alpha_q;
  logic signed [SCORE_BITS-1:0] beta_q;
  logic signed [SCORE_BITS-1:0] slot_score;
  logic                         hit;
  logic                         known;
  logic signed [SCORE_BITS-1:0] score;
  logic [MOVE_BITS-1:0]         move;
  logic                         rsp_valid_q;
  logic                         rsp_known_q;
  logic signed [SCORE_BITS-1:0] rsp_score_q;
  logic [MOVE_BITS-1:0]         rsp_move_q;

  assign req_idx = req_key_i[SLOT_BITS-1:0];

  // entry built from the incoming record
  always_comb begin
    rec_slot.valid = 1'b1;
    rec_slot.score = req_score_i;
    rec_slot.bound = req_bound_i;
    rec_slot.depth = req_depth_i;
    rec_slot.move  = req_move_i;
    rec_slot.key   = req_key_i;
  end

  // write port shared by the clearing sweep and records
  assign wr_en   = cmd_i.sweep_step | cmd_i.wr_record;
  assign wr_addr = cmd_i.sweep_step ? sweep_cnt_q : req_idx;
  assign wr_data = cmd_i.sweep_step ? slot_t'('0) : rec_slot;

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_probe) begin
      rdata_q <= slot_mem_q[req_idx];
    end
  end

  // sweep counter walks every slot once per clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep_step) begin
      sweep_cnt_q <= sweep_cnt_q + 1'b1;
    end
  end

  assign sts_o.sweep_last = &sweep_cnt_q;
  assign sts_o.out_free   = !rsp_valid_q || rsp_ready_i;

  // probe fields held while the slot is read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q   <= req_key_i;
      depth_q <= req_depth_i;
      alpha_q <= req_alpha_i;
      beta_q  <= req_beta_i;
    end
  end

  // probe decision on the read slot
  assign slot_score = rdata_q.score;
  assign hit = rdata_q.valid && (rdata_q.key == key_q) && (rdata_q.depth >= depth_q);

  always_comb begin
    known = 1'b0;
    score = '0;
    move  = '0;
    if (cmd_i.out_probe) begin
      move = rdata_q.move;
      if (hit) begin
        case (rdata_q.bound)
          BOUND_EXACT: begin
            known = 1'b1;
            score = slot_score;
          end
          BOUND_UPPER: begin
            if (slot_score <= alpha_q) begin
              known = 1'b1;
              score = alpha_q;
            end
          end
          BOUND_LOWER: begin
            if (slot_score >= beta_q) begin
              known = 1'b1;
              score = beta_q;
            end
          end
          default: begin
            // no rule for the unused bound code
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_known_q <= known;
      rsp_score_q <= score;
      rsp_move_q  <= move;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_known_o = rsp_known_q;
  assign rsp_score_o = rsp_score_q;
  assign rsp_move_o  = rsp_move_q;

endmodule

/* sv/transposition_table_probe_store_top.sv */
// top level of the direct-mapped transposition table probe store
// Direct-mapped table of 4096 slots chosen by the low 12 key bits. After reset
// the block zeroes every slot in a sweep and takes no item until it is done.
// Record, probe and the unused mode are accepted in the idle state (a probe
// issues its read of the slot memory there), then the result is loaded into
// the output register once it is free; the block takes no new item before
// that load. A clear item zeroes the table through the same write port, one
// slot a cycle: the accept, the sweep over every slot, then the load of its
// all-zero result. The output register lets the next item in while a result
// still waits to be taken.
module transposition_table_probe_store_top import ttps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttps_req_if.sink    req_i,
  ttps_rsp_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // controller
  ttps_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_i.valid),
    .req_mode_i      (req_i.mode),
    .req_cancelled_i (req_i.cancelled),
    .req_ready_o     (req_i.ready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // datapath
  ttps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_key_i   (req_i.position_key),
    .req_depth_i (req_i.search_depth),
    .req_alpha_i (req_i.window_low),
    .req_beta_i  (req_i.window_high),
    .req_score_i (req_i.store_score),
    .req_bound_i (req_i.bound_kind),
    .req_move_i  (req_i.best_move),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_known_o (rsp_o.score_known),
    .rsp_score_o (rsp_o.score),
    .rsp_move_o  (rsp_o.stored_move)
  );

  // no item is taken while the sweep owns the write port
  a_no_accept_in_sweep: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.sweep_step |-> !req_i.ready
  ) else $error("item accepted during clearing sweep");

  // a result appears only after the controller loaded it
  a_rsp_from_load: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(rsp_o.valid) |-> $past(cmd.load_out)
  ) else $error("result valid without a load");

  // a held result is never overwritten
  a_load_when_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (rsp_o.valid && !rsp_o.ready) |-> !cmd.load_out
  ) else $error("result register overwritten while stalled");

  // a probe read sets the result source to the read slot
  a_probe_then_load: assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.rd_probe |=> cmd.out_probe
  ) else $error("probe result source lost");

endmodule

/* tb/sv/testbench.sv */
// testbench of the transposition table: directed table and random items checked by a table predictor
module testbench;
  import ttps_pkg::*;

  // codes the package leaves unnamed
  localparam logic [MODE_BITS-1:0]  MODE_UNUSED  = 2'd3;
  localparam logic [BOUND_BITS-1:0] BOUND_UNUSED = 2'd3;

  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PRINT_LIMIT  = 20;
  localparam int POOL_SIZE    = 16;

  // keys of the directed part, each in its own slot
  localparam logic [KEY_BITS-1:0] KEY_A   = 64'hDEAD_BEEF_0123_4ABC;
  localparam logic [KEY_BITS-1:0] KEY_B   = 64'h0123_4567_89AB_C001;
  localparam logic [KEY_BITS-1:0] KEY_C   = 64'hFEDC_BA98_7654_3800;
  localparam logic [KEY_BITS-1:0] KEY_D   = 64'h5555_AAAA_5555_A7FF;
  localparam logic [KEY_BITS-1:0] KEY_TOP = 64'h8000_0000_0000_0000;
  localparam logic [KEY_BITS-1:0] KEY_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [KEY_BITS-1:0]   position_key;
    logic [DEPTH_BITS-1:0] search_depth;
    logic [SCORE_BITS-1:0] window_low;
    logic [SCORE_BITS-1:0] window_high;
    logic [SCORE_BITS-1:0] store_score;
    logic [BOUND_BITS-1:0] bound_kind;
    logic [MOVE_BITS-1:0]  best_move;
    logic                  cancelled;
  } tt_item_t;

  typedef struct packed {
    logic                  score_known;
    logic [SCORE_BITS-1:0] score;
    logic [MOVE_BITS-1:0]  stored_move;
  } tt_result_t;

  typedef struct {
    tt_item_t   item;
    bit         typed;
    tt_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   fail_count;

  tt_result_t pending_results[$];
  dir_row_t   dir_rows[$];

  // predictor copy of the table
  logic [KEY_BITS-1:0]   tbl_key   [SLOT_COUNT];
  logic                  tbl_valid [SLOT_COUNT];
  logic [DEPTH_BITS-1:0] tbl_depth [SLOT_COUNT];
  logic [BOUND_BITS-1:0] tbl_bound [SLOT_COUNT];
  logic [SCORE_BITS-1:0] tbl_score [SLOT_COUNT];
  logic [MOVE_BITS-1:0]  tbl_move  [SLOT_COUNT];

  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

  ttps_req_if req_ch ();
  ttps_rsp_if rsp_ch ();

  transposition_table_probe_store_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // invalidate every slot of the predictor table
  function automatic void wipe_table_model();
    for (int s = 0; s < SLOT_COUNT; s++) begin
      tbl_key[s]   = '0;
      tbl_valid[s] = 1'b0;
      tbl_depth[s] = '0;
      tbl_bound[s] = '0;
      tbl_score[s] = '0;
      tbl_move[s]  = '0;
    end
  endfunction

  // apply one item to the predictor table and return the result it causes
  function automatic tt_result_t apply_to_table(input tt_item_t it);
    tt_result_t            res;
    logic [SLOT_BITS-1:0]  idx;
    idx = it.position_key[SLOT_BITS-1:0];
    res = '0;
    case (it.mode)
      MODE_RECORD: begin
        if (!it.cancelled) begin
          tbl_key[idx]   = it.position_key;
          tbl_valid[idx] = 1'b1;
          tbl_depth[idx] = it.search_depth;
          tbl_bound[idx] = it.bound_kind;
          tbl_score[idx] = it.store_score;
          tbl_move[idx]  = it.best_move;
        end
      end
      MODE_PROBE: begin
        res.stored_move = tbl_move[idx];
        if (tbl_valid[idx] && tbl_key[idx] == it.position_key &&
            tbl_depth[idx] >= it.search_depth) begin
          if (tbl_bound[idx] == BOUND_EXACT) begin
            res.score_known = 1'b1;
            res.score       = tbl_score[idx];
          end else if (tbl_bound[idx] == BOUND_UPPER &&
                       $signed(tbl_score[idx]) <= $signed(it.window_low)) begin
            res.score_known = 1'b1;
            res.score       = it.window_low;
          end else if (tbl_bound[idx] == BOUND_LOWER &&
                       $signed(tbl_score[idx]) >= $signed(it.window_high)) begin
            res.score_known = 1'b1;
            res.score       = it.window_high;
          end
        end
      end
      MODE_CLEAR: wipe_table_model();
      default: ;
    endcase
    return res;
  endfunction

  function automatic tt_item_t mk_item(input logic [MODE_BITS-1:0] mode,
                                       input logic [KEY_BITS-1:0] key,
                                       input logic [DEPTH_BITS-1:0] depth,
                                       input int lo, input int hi, input int sc,
                                       input logic [BOUND_BITS-1:0] bound,
                                       input logic [MOVE_BITS-1:0] move,
                                       input logic cancel);
    tt_item_t it;
    it.mode         = mode;
    it.position_key = key;
    it.search_depth = depth;
    it.window_low   = 16'(lo);
    it.window_high  = 16'(hi);
    it.store_score  = 16'(sc);
    it.bound_kind   = bound;
    it.best_move    = move;
    it.cancelled    = cancel;
    return it;
  endfunction

  function automatic tt_result_t mk_res(input logic known, input int sc,
                                        input logic [MOVE_BITS-1:0] move);
    tt_result_t res;
    res.score_known = known;
    res.score       = 16'(sc);
    res.stored_move = move;
    return res;
  endfunction

  function automatic void add_row(input tt_item_t it, input bit typed, input tt_result_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // a window bound a few steps from a stored score, kept in range
  function automatic logic [SCORE_BITS-1:0] near_score(input logic [SCORE_BITS-1:0] base);
    int v;
    v = $signed(base) + int'($urandom_range(0, 6)) - 3;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("mismatch: %s", what);
  endtask

  // present one item and hold it until taken
  task automatic drive_item(input tt_item_t it);
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= it.mode;
    req_ch.position_key <= it.position_key;
    req_ch.search_depth <= it.search_depth;
    req_ch.window_low   <= it.window_low;
    req_ch.window_high  <= it.window_high;
    req_ch.store_score  <= it.store_score;
    req_ch.bound_kind   <= it.bound_kind;
    req_ch.best_move    <= it.best_move;
    req_ch.cancelled    <= it.cancelled;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // random gap on the request side, mostly short and now and then long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (steady || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // compare one taken result item with the oldest expectation
  task automatic check_result();
    tt_result_t want;
    if (pending_results.size() == 0) begin
      report("result item with nothing expected");
    end else begin
      want = pending_results.pop_front();
      if (rsp_ch.score_known !== want.score_known)
        report($sformatf("score_known %b, expected %b", rsp_ch.score_known, want.score_known));
      if (rsp_ch.score !== want.score)
        report($sformatf("score %0d, expected %0d", rsp_ch.score, $signed(want.score)));
      if (rsp_ch.stored_move !== want.stored_move)
        report($sformatf("stored_move %h, expected %h", rsp_ch.stored_move, want.stored_move));
    end
  endtask

  // response side: back-pressure and checking
  initial begin : response_side
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
      if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item taken on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus and end of run
  initial begin : request_side
    tt_item_t             it;
    tt_result_t           res;
    logic [SLOT_BITS-1:0] idx;
    int                   r;
    int                   q;

    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= MODE_RECORD;
    req_ch.position_key <= '0;
    req_ch.search_depth <= '0;
    req_ch.window_low   <= '0;
    req_ch.window_high  <= '0;
    req_ch.store_score  <= '0;
    req_ch.bound_kind   <= BOUND_EXACT;
    req_ch.best_move    <= '0;
    req_ch.cancelled    <= 1'b0;
    steady     = 1'b0;
    fail_count = 0;
    wipe_table_model();
    for (int j = 0; j < POOL_SIZE; j++) begin
      key_pool[j] = {$urandom, $urandom};
      if (j < POOL_SIZE / 2) key_pool[j][SLOT_BITS-1:0] = SLOT_BITS'(j % 3);
    end

    // directed rows: empty table, extremes, every bound rule, clear and unused codes
    add_row(mk_item(MODE_PROBE, '0, 0, 0, 0, 0, BOUND_EXACT, 0, 0), 1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_PROBE, KEY_MAX, 0, 0, 0, 0, BOUND_EXACT, 0, 0), 1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_RECORD, KEY_A, 255, 0, 0, 32767, BOUND_EXACT, 16'hFFFF, 0),
            1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_PROBE, KEY_A, 255, 0, 0, 0, BOUND_EXACT, 0, 0),
            1, mk_res(1, 32767, 16'hFFFF));
    add_row(mk_item(MODE_PROBE, KEY_A, 0, -32768, 32767, 0, BOUND_EXACT, 0, 0),
            1, mk_res(1, 32767, 16'hFFFF));
    // same slot, other key: move comes back, score does not
    add_row(mk_item(MODE_PROBE, KEY_A ^ KEY_TOP, 0, 0, 0, 0, BOUND_EXACT, 0, 0),
            1, mk_res(0, 0, 16'hFFFF));
    // cancelled record leaves the slot alone
    add_row(mk_item(MODE_RECORD, KEY_A ^ KEY_TOP, 9, 0, 0, -1, BOUND_EXACT, 16'h1234, 1),
            1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_PROBE, KEY_A, 128, 0, 0, 0, BOUND_EXACT, 0, 0), 0, '0);
    // upper bound: depth rule and alpha rule
    add_row(mk_item(MODE_RECORD, KEY_B, 10, 0, 0, 100, BOUND_UPPER, 16'h0001, 0),
            1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_PROBE, KEY_B, 11, 200, 0, 0, BOUND_EXACT, 0, 0),
            1, mk_res(0, 0, 16'h0001));
    add_row(mk_item(MODE_PROBE, KEY_B, 10, 99, 0, 0, BOUND_EXACT, 0, 0),
            1, mk_res(0, 0, 16'h0001));
    add_row(mk_item(MODE_PROBE, KEY_B, 10, 100, 0, 0, BOUND_EXACT, 0, 0),
            1, mk_res(1, 100, 16'h0001));
    add_row(mk_item(MODE_PROBE, KEY_B, 0, 32767, -32768, 0, BOUND_EXACT, 0, 0), 0, '0);
    // lower bound: beta rule
    add_row(mk_item(MODE_RECORD, KEY_C, 0, 0, 0, -5, BOUND_LOWER, 16'h8000, 0),
            1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_PROBE, KEY_C, 0, 0, -4, 0, BOUND_EXACT, 0, 0),
            1, mk_res(0, 0, 16'h8000));
    add_row(mk_item(MODE_PROBE, KEY_C, 0, 0, -5, 0, BOUND_EXACT, 0, 0),
            1, mk_res(1, -5, 16'h8000));
    add_row(mk_item(MODE_PROBE, KEY_C, 0, 32767, -32768, 0, BOUND_EXACT, 0, 0), 0, '0);
    // unused bound kind stored: no rule applies
    add_row(mk_item(MODE_RECORD, KEY_D, 200, 0, 0, 7, BOUND_UNUSED, 16'h7777, 0), 0, '0);
    add_row(mk_item(MODE_PROBE, KEY_D, 0, 32767, -32768, 0, BOUND_EXACT, 0, 0),
            1, mk_res(0, 0, 16'h7777));
    add_row(mk_item(MODE_UNUSED, KEY_A, 255, -1, -1, -1, BOUND_UNUSED, 16'hFFFF, 1),
            1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_CLEAR, KEY_MAX, 255, -1, -1, -1, BOUND_UNUSED, 16'hFFFF, 1),
            1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_PROBE, KEY_A, 0, 0, 0, 0, BOUND_EXACT, 0, 0), 1, mk_res(0, 0, 0));
    add_row(mk_item(MODE_RECORD, KEY_MAX, 0, 0, 0, -32768, BOUND_EXACT, 0, 0), 0, '0);
    add_row(mk_item(MODE_PROBE, KEY_MAX, 0, 0, 0, 0, BOUND_EXACT, 0, 0),
            1, mk_res(1, -32768, 0));
    add_row(mk_item(MODE_PROBE, KEY_C, 0, 0, -32768, 0, BOUND_EXACT, 0, 0),
            1, mk_res(0, 0, 0));

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      drive_item(dir_rows[k].item);
      res = apply_to_table(dir_rows[k].item);
      pending_results.push_back(dir_rows[k].typed ? dir_rows[k].want : res);
      sender_gap();
    end

    // random part: records and probes mostly on a small pool of keys
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = ((n / 150) % 4 == 2);
      it.mode         = MODE_PROBE;
      it.position_key = {$urandom, $urandom};
      it.search_depth = 8'($urandom);
      it.window_low   = 16'($urandom);
      it.window_high  = 16'($urandom);
      it.store_score  = 16'($urandom);
      it.bound_kind   = 2'($urandom);
      it.best_move    = 16'($urandom);
      it.cancelled    = 1'($urandom);
      r = $urandom_range(0, 99);
      if (r == 0) begin
        it.mode = MODE_CLEAR;
      end else if (r == 1) begin
        it.mode = MODE_UNUSED;
      end else if (r < 36) begin
        it.mode = MODE_RECORD;
        if ($urandom_range(0, 9) < 7)
          it.position_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if ($urandom_range(0, 2) == 0)
          key_pool[$urandom_range(0, POOL_SIZE - 1)] = it.position_key;
        it.cancelled  = ($urandom_range(0, 9) == 0);
        it.bound_kind = ($urandom_range(0, 19) == 0) ? BOUND_UNUSED : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0) it.search_depth = 8'($urandom_range(0, 15));
      end else begin
        q = $urandom_range(0, 9);
        if (q < 8) it.position_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (q == 7)
          it.position_key ^= 64'h1 << $urandom_range(SLOT_BITS, KEY_BITS - 1);
        idx = it.position_key[SLOT_BITS-1:0];
        if ($urandom_range(0, 1) == 0)
          it.search_depth = 8'($urandom_range(0, int'(tbl_depth[idx])));
        if ($urandom_range(0, 1) == 0) it.window_low = near_score(tbl_score[idx]);
        if ($urandom_range(0, 1) == 0) it.window_high = near_score(tbl_score[idx]);
      end
      drive_item(it);
      pending_results.push_back(apply_to_table(it));
      // let the pipeline drain completely a couple of times
      if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end else begin
        sender_gap();
      end
    end
    steady = 1'b0;

    // wait for the last results, then for any stray result items
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
